@@ sv/mmas_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmas_pkg: shared types and constants
// Operation codes, controller-to-datapath command and write groups, and the
// saturation limits for signed 32-bit results.
// ----------------------------------------------------------------------------
package mmas_pkg;

    typedef enum logic [2:0] {
        OP_LOAD_A = 3'd0,
        OP_LOAD_B = 3'd1,
        OP_MUL    = 3'd2,
        OP_ADD    = 3'd3,
        OP_SUB    = 3'd4
    } mmas_op_t;

    // One product term or one sum/difference issued to the datapath
    typedef struct packed {
        logic       issue;
        logic       first;
        logic       last;
        logic       mul;
        logic       sub;
        logic [3:0] res_index;
        logic       res_last;
    } mmas_cmd_t;

    typedef struct packed {
        logic wr_a;
        logic wr_b;
    } mmas_wr_t;

    localparam logic signed [31:0] SAT_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

endpackage
`default_nettype wire

@@ sv/matrix4_multiply_add_sub_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// matrix4_multiply_add_sub_top: DIM x DIM fixed-point matrix multiply/add/sub
// Load items write one element of A or B. A compute item returns DIM*DIM
// elements in row-major order, last one flagged. One shared
// multiplier-accumulator takes one product term per cycle within an element
// through a four-stage read/multiply/accumulate/saturate pipeline, and the
// next element starts once the previous one has left the output register.
// Input stalls while a compute item is being sequenced. Both stores read as
// zero after reset until written; no clearing pass is needed.
// ----------------------------------------------------------------------------
module matrix4_multiply_add_sub_top #(
    parameter int DIM       = 4,
    parameter int FRAC_BITS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [2:0]         op,
    input  wire logic [3:0]         elem_index,
    input  wire logic signed [31:0] elem_value,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [3:0]              res_index,
    output logic signed [31:0]      res_value,
    output logic                    res_last
);
    import mmas_pkg::*;

    localparam int AW = $clog2(DIM * DIM);

    mmas_cmd_t       cmd;
    mmas_wr_t        wr;
    logic [AW-1:0]   wr_addr;
    logic [AW-1:0]   rd_addr_a;
    logic [AW-1:0]   rd_addr_b;
    logic            pipe_idle;

    mmas_ctrl #(
        .DIM (DIM)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .elem_index (elem_index),
        .pipe_idle  (pipe_idle),
        .cmd        (cmd),
        .wr         (wr),
        .wr_addr    (wr_addr),
        .rd_addr_a  (rd_addr_a),
        .rd_addr_b  (rd_addr_b)
    );

    mmas_dpath #(
        .DIM       (DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .wr        (wr),
        .wr_addr   (wr_addr),
        .wr_data   (elem_value),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .pipe_idle (pipe_idle),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res_index (res_index),
        .res_value (res_value),
        .res_last  (res_last)
    );

endmodule
`default_nettype wire

@@ sv/mmas_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmas_ctrl: sequencing controller
// Decodes input items into store writes, and walks the result elements and
// their product terms for compute items, one issued per cycle in an element.
// ----------------------------------------------------------------------------
module mmas_ctrl #(
    parameter int DIM = 4
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [2:0]                         op,
    input  wire logic [3:0]                         elem_index,
    input  wire logic                               pipe_idle,
    output mmas_pkg::mmas_cmd_t                     cmd,
    output mmas_pkg::mmas_wr_t                      wr,
    output logic [$clog2(DIM*DIM)-1:0]              wr_addr,
    output logic [$clog2(DIM*DIM)-1:0]              rd_addr_a,
    output logic [$clog2(DIM*DIM)-1:0]              rd_addr_b
);
    import mmas_pkg::*;

    localparam int CELLS = DIM * DIM;
    localparam int AW    = $clog2(CELLS);
    localparam int DW    = $clog2(DIM);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WAIT,
        ST_ISSUE
    } state_t;

    state_t          state_reg;
    logic            mul_reg;
    logic            sub_reg;
    logic [DW-1:0]   row_reg;
    logic [DW-1:0]   col_reg;
    logic [DW-1:0]   k_reg;
    logic [AW-1:0]   elem_reg;

    logic            in_fire;
    logic            is_compute;
    logic            idx_ok;
    logic            k_done;
    logic            elem_done;

    assign in_stall   = (state_reg != ST_IDLE);
    assign in_fire    = in_valid && !in_stall;
    assign is_compute = (op == OP_MUL) || (op == OP_ADD) || (op == OP_SUB);
    assign idx_ok     = int'(elem_index) < CELLS;

    assign wr.wr_a = in_fire && (op == OP_LOAD_A) && idx_ok;
    assign wr.wr_b = in_fire && (op == OP_LOAD_B) && idx_ok;
    assign wr_addr = AW'(elem_index);

    assign k_done    = !mul_reg || (k_reg == DW'(DIM - 1));
    assign elem_done = (elem_reg == AW'(CELLS - 1));

    assign cmd.issue     = (state_reg == ST_ISSUE);
    assign cmd.first     = !mul_reg || (k_reg == '0);
    assign cmd.last      = k_done;
    assign cmd.mul       = mul_reg;
    assign cmd.sub       = sub_reg;
    assign cmd.res_index = 4'(elem_reg);
    assign cmd.res_last  = elem_done;

    always_comb
    begin
        if (mul_reg)
        begin
            rd_addr_a = AW'(row_reg) * AW'(DIM) + AW'(k_reg);
            rd_addr_b = AW'(k_reg) * AW'(DIM) + AW'(col_reg);
        end
        else
        begin
            rd_addr_a = elem_reg;
            rd_addr_b = elem_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mul_reg   <= 1'b0;
            sub_reg   <= 1'b0;
            row_reg   <= '0;
            col_reg   <= '0;
            k_reg     <= '0;
            elem_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire && is_compute)
                    begin
                        mul_reg   <= (op == OP_MUL);
                        sub_reg   <= (op == OP_SUB);
                        row_reg   <= '0;
                        col_reg   <= '0;
                        k_reg     <= '0;
                        elem_reg  <= '0;
                        state_reg <= ST_WAIT;
                    end
                end
                ST_WAIT:
                begin
                    if (pipe_idle)
                    begin
                        state_reg <= ST_ISSUE;
                    end
                end
                ST_ISSUE:
                begin
                    if (k_done)
                    begin
                        k_reg <= '0;
                        if (elem_done)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            elem_reg  <= elem_reg + AW'(1);
                            state_reg <= ST_WAIT;
                            if (col_reg == DW'(DIM - 1))
                            begin
                                col_reg <= '0;
                                row_reg <= row_reg + DW'(1);
                            end
                            else
                            begin
                                col_reg <= col_reg + DW'(1);
                            end
                        end
                    end
                    else
                    begin
                        k_reg <= k_reg + DW'(1);
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_first_needs_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.issue && cmd.first) |-> pipe_idle)
        else $error("element started while pipeline busy");

    a_compute_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && is_compute) |=> in_stall)
        else $error("compute transfer did not block input");

    a_end_of_item: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.issue && cmd.last && cmd.res_last) |=> (!cmd.issue && !in_stall))
        else $error("controller did not return to idle after last element");
`endif

endmodule
`default_nettype wire

@@ sv/mmas_dpath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmas_dpath: matrix stores and arithmetic pipeline
// Holds A and B in memories with per-entry valid bits, then reads, multiplies
// or adds, accumulates, shifts, saturates and registers each result element.
// ----------------------------------------------------------------------------
module mmas_dpath #(
    parameter int DIM       = 4,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire mmas_pkg::mmas_cmd_t                cmd,
    input  wire mmas_pkg::mmas_wr_t                 wr,
    input  wire logic [$clog2(DIM*DIM)-1:0]         wr_addr,
    input  wire logic signed [31:0]                 wr_data,
    input  wire logic [$clog2(DIM*DIM)-1:0]         rd_addr_a,
    input  wire logic [$clog2(DIM*DIM)-1:0]         rd_addr_b,
    output logic                                    pipe_idle,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [3:0]                              res_index,
    output logic signed [31:0]                      res_value,
    output logic                                    res_last
);
    import mmas_pkg::*;

    localparam int CELLS = DIM * DIM;
    localparam int ACC_W = 64 + $clog2(DIM);

    logic signed [31:0]      mem_a [CELLS];
    logic signed [31:0]      mem_b [CELLS];
    logic [CELLS-1:0]        va_reg;
    logic [CELLS-1:0]        vb_reg;

    logic signed [31:0]      a_q_reg;
    logic signed [31:0]      b_q_reg;
    logic                    a_v_reg;
    logic                    b_v_reg;
    mmas_cmd_t               s1_reg;

    logic signed [63:0]      p_reg;
    mmas_cmd_t               s2_reg;

    logic signed [ACC_W-1:0] acc_reg;
    mmas_cmd_t               s3_reg;
    logic                    s3_done_reg;

    logic                    out_valid_reg;
    logic [3:0]              res_index_reg;
    logic signed [31:0]      res_value_reg;
    logic                    res_last_reg;

    logic signed [31:0]      a_val;
    logic signed [31:0]      b_val;
    logic signed [63:0]      prod;
    logic signed [32:0]      sum;
    logic signed [63:0]      p_next;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [ACC_W-1:0] shifted;
    logic [ACC_W-32:0]       hi_bits;
    logic signed [31:0]      sat_value;

    always_ff @(posedge clk)
    begin
        if (wr.wr_a)
        begin
            mem_a[wr_addr] <= wr_data;
        end
        if (wr.wr_b)
        begin
            mem_b[wr_addr] <= wr_data;
        end
        a_q_reg <= mem_a[rd_addr_a];
        b_q_reg <= mem_b[rd_addr_b];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg  <= '0;
            vb_reg  <= '0;
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
        end
        else
        begin
            if (wr.wr_a)
            begin
                va_reg[wr_addr] <= 1'b1;
            end
            if (wr.wr_b)
            begin
                vb_reg[wr_addr] <= 1'b1;
            end
            a_v_reg <= va_reg[rd_addr_a];
            b_v_reg <= vb_reg[rd_addr_b];
        end
    end

    assign a_val = a_v_reg ? a_q_reg : '0;
    assign b_val = b_v_reg ? b_q_reg : '0;

    always_comb
    begin
        prod = a_val * b_val;
        if (s1_reg.sub)
        begin
            sum = 33'(a_val) - 33'(b_val);
        end
        else
        begin
            sum = 33'(a_val) + 33'(b_val);
        end
        p_next = s1_reg.mul ? prod : 64'(sum);
    end

    assign acc_next = s2_reg.first ? ACC_W'(p_reg) : acc_reg + ACC_W'(p_reg);

    always_comb
    begin
        shifted   = s3_reg.mul ? (acc_reg >>> FRAC_BITS) : acc_reg;
        hi_bits   = shifted[ACC_W-1:31];
        if ((&hi_bits) || !(|hi_bits))
        begin
            sat_value = shifted[31:0];
        end
        else
        begin
            sat_value = shifted[ACC_W-1] ? SAT_MIN : SAT_MAX;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
        if (s2_reg.issue)
        begin
            acc_reg <= acc_next;
        end
        if (s3_done_reg)
        begin
            res_index_reg <= s3_reg.res_index;
            res_value_reg <= sat_value;
            res_last_reg  <= s3_reg.res_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg        <= '0;
            s2_reg        <= '0;
            s3_reg        <= '0;
            s3_done_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_reg      <= cmd;
            s2_reg      <= s1_reg;
            s3_reg      <= s2_reg;
            s3_done_reg <= s2_reg.issue && s2_reg.last;
            if (s3_done_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign pipe_idle = !s1_reg.issue && !s2_reg.issue && !s3_done_reg && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign res_index = res_index_reg;
    assign res_value = res_value_reg;
    assign res_last  = res_last_reg;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        s3_done_reg |-> !out_valid_reg)
        else $error("result overwrote a pending output");

    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_stall) |=> !out_valid_reg)
        else $error("output refilled right after transfer");

    a_sum_single_term: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_reg.issue && !s1_reg.mul) |-> (s1_reg.first && s1_reg.last))
        else $error("sum or difference spans several terms");
`endif

endmodule
`default_nettype wire

@@ tb/matrix4_multiply_add_sub_check.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix4_multiply_add_sub_check: result predictor and comparator
// Watches both channels of the matrix block. Keeps its own copy of the A and B
// stores, queues the sixteen predicted elements of every multiply, add or
// subtract transfer, and compares each output transfer field by field with
// the oldest queued element.
// ----------------------------------------------------------------------------
module matrix4_multiply_add_sub_check #(
    parameter int DIM       = 4,
    parameter int FRAC_BITS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_stall,
    input  wire logic [2:0]         op,
    input  wire logic [3:0]         elem_index,
    input  wire logic signed [31:0] elem_value,
    input  wire logic               out_valid,
    input  wire logic               out_stall,
    input  wire logic [3:0]         res_index,
    input  wire logic signed [31:0] res_value,
    input  wire logic               res_last,
    output int                      fail_count,
    output int                      pending,
    output int                      result_count
);
    import mmas_pkg::*;

    localparam int CELLS = DIM * DIM;

    typedef struct packed {
        logic [3:0]         idx;
        logic signed [31:0] value;
        logic               last;
    } mmas_elem_t;

    logic signed [31:0] mat_a [CELLS];
    logic signed [31:0] mat_b [CELLS];
    mmas_elem_t         elem_q [$];
    mmas_elem_t         oldest;

    function automatic logic signed [31:0] clamp32(input logic signed [67:0] v);
        logic signed [67:0] hi_lim;
        logic signed [67:0] lo_lim;
        hi_lim = SAT_MAX;
        lo_lim = SAT_MIN;
        if (v > hi_lim)
            return SAT_MAX;
        if (v < lo_lim)
            return SAT_MIN;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] dot_cell(input int row, input int col);
        logic signed [67:0] acc;
        logic signed [63:0] prod;
        acc = '0;
        for (int k = 0; k < DIM; k++)
        begin
            prod = mat_a[row * DIM + k] * mat_b[k * DIM + col];
            acc = acc + prod;
        end
        acc = acc >>> FRAC_BITS;
        return clamp32(acc);
    endfunction

    task automatic note_failure(input string msg);
        if (fail_count < 10)
            $display("MISMATCH: %s", msg);
        fail_count++;
    endtask

    task automatic absorb_request(input logic [2:0] code, input logic [3:0] pos,
                                  input logic signed [31:0] value);
        logic signed [67:0] wide;
        logic signed [31:0] v;
        case (code)
            OP_LOAD_A:
                if (pos < CELLS)
                    mat_a[pos] = value;
            OP_LOAD_B:
                if (pos < CELLS)
                    mat_b[pos] = value;
            OP_MUL, OP_ADD, OP_SUB:
                for (int i = 0; i < CELLS; i++)
                begin
                    wide = mat_a[i];
                    if (code == OP_MUL)
                        v = dot_cell(i / DIM, i % DIM);
                    else if (code == OP_ADD)
                        v = clamp32(wide + mat_b[i]);
                    else
                        v = clamp32(wide - mat_b[i]);
                    elem_q.push_back('{4'(i), v, i == CELLS - 1});
                end
            default:
                ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CELLS; i++)
            begin
                mat_a[i] = '0;
                mat_b[i] = '0;
            end
            elem_q.delete();
            fail_count = 0;
            pending = 0;
            result_count = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                result_count++;
                if (elem_q.size() == 0)
                    note_failure($sformatf("unexpected result idx %0d value %h last %0b",
                                           res_index, res_value, res_last));
                else
                begin
                    oldest = elem_q.pop_front();
                    if (oldest.idx !== res_index || oldest.value !== res_value
                        || oldest.last !== res_last)
                        note_failure($sformatf(
                            "expected idx %0d value %h last %0b, got idx %0d value %h last %0b",
                            oldest.idx, oldest.value, oldest.last,
                            res_index, res_value, res_last));
                end
            end
            if (in_valid && !in_stall)
                absorb_request(op, elem_index, elem_value);
            pending = elem_q.size();
        end
    end

endmodule

@@ tb/matrix4_multiply_add_sub_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix4_multiply_add_sub_top_test: stimulus and verdict
// Drives load, compute and unused-code transfers into the matrix block with
// bursty input and a varying output stall pattern. A directed opening covers
// zero stores, saturation both ways, truncation and ignored fields; random
// load sequences ending in a compute, lone computes and unused codes follow.
// ----------------------------------------------------------------------------
module matrix4_multiply_add_sub_top_test;
    import mmas_pkg::*;

    localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;
    localparam logic [2:0] OP_LAST_CODE    = 3'd7;
    localparam int         CYCLE_LIMIT     = 400000;
    localparam int         RANDOM_ITEMS    = 110;

    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               in_valid   = 1'b0;
    logic               in_stall;
    logic [2:0]         op         = OP_LOAD_A;
    logic [3:0]         elem_index = '0;
    logic signed [31:0] elem_value = '0;
    logic               out_valid;
    logic               out_stall  = 1'b0;
    logic [3:0]         res_index;
    logic signed [31:0] res_value;
    logic               res_last;

    int fail_count;
    int pending;
    int result_count;
    int cycle_count   = 0;
    int burst_left    = 0;
    int stall_mode    = 0;
    int stall_left    = 0;
    int sent_loads    = 0;
    int sent_computes = 0;
    int sent_ignored  = 0;

    matrix4_multiply_add_sub_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .elem_index (elem_index),
        .elem_value (elem_value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .res_index  (res_index),
        .res_value  (res_value),
        .res_last   (res_last)
    );

    matrix4_multiply_add_sub_check result_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .elem_index   (elem_index),
        .elem_value   (elem_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .res_index    (res_index),
        .res_value    (res_value),
        .res_last     (res_last),
        .fail_count   (fail_count),
        .pending      (pending),
        .result_count (result_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(10, 120);
        end
        else
            stall_left--;
        case (stall_mode)
            0: out_stall = 1'b0;
            1: out_stall = ($urandom_range(0, 3) == 0);
            2: out_stall = ($urandom_range(0, 3) != 0);
            default: out_stall = (stall_left % 5 < 2);
        endcase
    end

    function automatic logic [31:0] pick_value();
        logic [31:0] mag;
        case ($urandom_range(0, 7))
            0: return SAT_MAX;
            1: return SAT_MIN;
            2: return '0;
            3: return '1;
            4, 5:
            begin
                mag = $urandom_range(0, 32'h0008_0000);
                return $urandom_range(0, 1) ? mag : -mag;
            end
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [2:0] pick_compute();
        case ($urandom_range(0, 2))
            0: return OP_MUL;
            1: return OP_ADD;
            default: return OP_SUB;
        endcase
    endfunction

    // hold the payload until the transfer happens
    task automatic send_item(input logic [2:0] code, input logic [3:0] pos,
                             input logic [31:0] value);
        if (burst_left == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(0, 8)) @(negedge clk);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        in_valid = 1'b1;
        op = code;
        elem_index = pos;
        elem_value = value;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
        if (code == OP_LOAD_A || code == OP_LOAD_B)
            sent_loads++;
        else if (code == OP_MUL || code == OP_ADD || code == OP_SUB)
            sent_computes++;
        else
            sent_ignored++;
    endtask

    task automatic drain_results();
        in_valid = 1'b0;
        burst_left = 0;
        while (pending != 0)
            @(negedge clk);
    endtask

    initial
    begin
        int random_items;
        int loads;
        bit mid_drain_done;
        random_items = 0;
        mid_drain_done = 1'b0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_item(OP_MUL, 4'd0, 32'd0);
        send_item(OP_ADD, 4'd3, 32'd0);
        send_item(OP_SUB, 4'd9, 32'd0);
        send_item(OP_LOAD_A, 4'd0, SAT_MAX);
        send_item(OP_LOAD_B, 4'd0, SAT_MAX);
        send_item(OP_LOAD_B, 4'd1, SAT_MIN);
        send_item(OP_LOAD_A, 4'd15, SAT_MIN);
        send_item(OP_LOAD_B, 4'd15, SAT_MAX);
        send_item(OP_LOAD_A, 4'd5, SAT_MAX);
        send_item(OP_LOAD_B, 4'd5, SAT_MIN);
        send_item(OP_LOAD_A, 4'd10, 32'hffff_ffff);
        send_item(OP_LOAD_B, 4'd10, 32'h0000_0001);
        send_item(OP_LOAD_A, 4'd6, 32'h0001_8000);
        send_item(OP_LOAD_B, 4'd9, 32'hfffe_4000);
        send_item(OP_MUL, 4'd15, 32'hffff_ffff);
        send_item(OP_ADD, 4'd7, 32'h5555_5555);
        send_item(OP_SUB, 4'd8, 32'haaaa_aaaa);
        for (int u = OP_FIRST_UNUSED; u <= OP_LAST_CODE; u++)
            send_item(3'(u), 4'($urandom_range(0, 15)), $urandom());
        send_item(OP_MUL, 4'd0, 32'd0);
        drain_results();

        while (random_items < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5, 6:
                begin
                    loads = $urandom_range(1, 10);
                    repeat (loads)
                        send_item($urandom_range(0, 1) ? OP_LOAD_B : OP_LOAD_A,
                                  4'($urandom_range(0, 15)), pick_value());
                    send_item(pick_compute(), 4'($urandom()), $urandom());
                    random_items += loads + 1;
                end
                7, 8:
                begin
                    send_item(pick_compute(), 4'($urandom()), $urandom());
                    random_items++;
                end
                default:
                    send_item(3'($urandom_range(OP_FIRST_UNUSED, OP_LAST_CODE)),
                              4'($urandom()), $urandom());
            endcase
            if (!mid_drain_done && random_items >= RANDOM_ITEMS / 2)
            begin
                drain_results();
                mid_drain_done = 1'b1;
            end
        end

        drain_results();
        repeat (40) @(negedge clk);

        $display("Covered %0d loads, %0d compute requests, %0d unused-code requests",
                 sent_loads, sent_computes, sent_ignored);
        $display("Checked %0d result transfers in %0d cycles, %0d mismatches",
                 result_count, cycle_count, fail_count);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ sim.f @@
sv/mmas_pkg.sv
sv/mmas_ctrl.sv
sv/mmas_dpath.sv
sv/matrix4_multiply_add_sub_top.sv
tb/matrix4_multiply_add_sub_check.sv
tb/matrix4_multiply_add_sub_top_test.sv
